/* src/pcpa_pkg.sv */
// Shared types, constants and helpers for the per-CPU page allocator.
`timescale 1ns / 1ps
package pcpa_pkg;

   // Sizing
   localparam int NUM_CPUS   = 3;
   localparam int NUM_PAGES  = 32768;
   localparam int PAGE_SHIFT = 12;

   localparam int ADDR_W     = 32;
   localparam int CPU_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int LIST_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int PAGE_IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_REGION_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_END   = 1'd1;

   localparam logic [ADDR_W-1:0] REGION_START_RESET = 32'h0000_0000;
   localparam logic [ADDR_W-1:0] REGION_END_RESET   = 32'h0800_0000;

   // Request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd2;

   // A list head or a link: page index plus valid (valid clear = end of list)
   typedef struct packed {
      logic                  valid;
      logic [PAGE_IDX_W-1:0] idx;
   } link_type;

   // Outcome of the free address check
   typedef struct packed {
      logic                  ok;
      logic [PAGE_IDX_W-1:0] idx;
   } check_type;

   // CPU number to owning list, out-of-range CPUs wrap round
   // (repeated compare and subtract over the few CPU codes)
   function automatic logic [LIST_W-1:0] list_of(input logic [CPU_W-1:0] cpu);
      logic [CPU_W-1:0] rem;
      rem = cpu;
      for (int k = 0; k < (1 << CPU_W); k++) begin
         if (int'(rem) >= NUM_CPUS) begin
            rem = rem - CPU_W'(NUM_CPUS);
         end
      end
      return LIST_W'(rem);
   endfunction

   // Page index to byte address, truncated to the address width
   function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_IDX_W-1:0] idx);
      logic [ADDR_W-1:0] wide;
      wide = ADDR_W'(idx);
      return wide << PAGE_SHIFT;
   endfunction

endpackage

/* src/pcpa_if.sv */
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
interface pcpa_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic [pcpa_pkg::CPU_W-1:0]        cpu;
   logic [pcpa_pkg::ADDR_W-1:0]       address;

   modport source (output valid, mode, cpu, address, input ready);
   modport sink   (input valid, mode, cpu, address, output ready);
endinterface

interface pcpa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pcpa_pkg::ADDR_W-1:0]       page_address;
   logic [pcpa_pkg::STATUS_W-1:0]     status;

   modport source (output valid, page_address, status, input ready);
   modport sink   (input valid, page_address, status, output ready);
endinterface

interface pcpa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pcpa_pkg::CSR_IDX_W-1:0]    index;
   logic [pcpa_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/per_cpu_page_free_list_allocator.sv */
// Per-CPU LIFO page allocator with stealing from the lowest non-empty list.
// Result: registered in the cycle after the request item is accepted.
// A free leaves the block ready for the next item; an allocate with a page
// waits in a pop state for the link read that becomes the list's new head.
// Reset: all lists empty, region_start 0, region_end 0x0800_0000; link
// memory is not cleared, every link is written by a push before it is read.
`timescale 1ns / 1ps
module per_cpu_page_free_list_allocator (
   input  logic       clock,
   input  logic       reset,
   pcpa_req_if.sink   req_ch,
   pcpa_rsp_if.source rsp_ch,
   pcpa_csr_if.sink   csr_ch
);
   import pcpa_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP  = 1'b1;

   // Registers
   logic                state_ff,        state_in;
   logic [LIST_W-1:0]   pop_list_ff,     pop_list_in;
   link_type            heads_ff [NUM_CPUS];
   link_type            heads_in [NUM_CPUS];
   logic                rsp_valid_ff,    rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_page_ff,     rsp_page_in;
   logic [STATUS_W-1:0] rsp_status_ff,   rsp_status_in;
   logic [ADDR_W-1:0]   region_start_ff, region_start_in;
   logic [ADDR_W-1:0]   region_end_ff,   region_end_in;

   // Working signals
   logic                accept;
   logic [LIST_W-1:0]   own_list;
   logic [LIST_W-1:0]   steal_list;
   logic                steal_found;
   logic [LIST_W-1:0]   alloc_list;
   logic                got_page;
   link_type            own_head;
   link_type            sel_head;
   check_type           chk;
   logic                ram_wr_en;
   logic                ram_rd_en;
   link_type            ram_rd_data;

   // Address check for frees
   pcpa_free_check u_check (
      .address      (req_ch.address),
      .region_start (region_start_ff),
      .region_end   (region_end_ff),
      .result       (chk)
   );

   // Link memory
   pcpa_link_ram u_links (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (chk.idx),
      .wr_data (own_head),
      .rd_en   (ram_rd_en),
      .rd_addr (sel_head.idx),
      .rd_data (ram_rd_data)
   );

   // Handshakes: a new item enters while idle and the result slot is free or draining
   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.page_address = rsp_page_ff;
   assign rsp_ch.status       = rsp_status_ff;

   // List selection: own list first, else lowest non-empty list
   assign own_list = list_of(req_ch.cpu);
   assign own_head = heads_ff[own_list];

   always_comb begin
      steal_found = 1'b0;
      steal_list  = '0;
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
         if (heads_ff[i].valid) begin
            steal_found = 1'b1;
            steal_list  = LIST_W'(i);
         end
      end
   end

   assign alloc_list = own_head.valid ? own_list : steal_list;
   assign got_page   = own_head.valid || steal_found;
   assign sel_head   = heads_ff[alloc_list];

   // Memory access: push writes the old head as the page's link, pop reads the link
   assign ram_wr_en = accept && (req_ch.mode == MODE_FREE) && chk.ok;
   assign ram_rd_en = accept && (req_ch.mode == MODE_ALLOC) && got_page;

   // Next state
   always_comb begin
      state_in        = state_ff;
      pop_list_in     = pop_list_ff;
      heads_in        = heads_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_page_in     = rsp_page_ff;
      rsp_status_in   = rsp_status_ff;
      region_start_in = region_start_ff;
      region_end_in   = region_end_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (ram_rd_en) begin
               state_in    = S_POP;
               pop_list_in = alloc_list;
            end
         end
         S_POP: begin
            // link read is back: it becomes the list head
            heads_in[pop_list_ff] = ram_rd_data;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // push
      if (ram_wr_en) begin
         heads_in[own_list].valid = 1'b1;
         heads_in[own_list].idx   = chk.idx;
      end

      // result slot
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_ch.mode == MODE_FREE) begin
            rsp_page_in   = '0;
            rsp_status_in = chk.ok ? ST_OK : ST_BAD_FREE;
         end else if (got_page) begin
            rsp_page_in   = page_addr(sel_head.idx);
            rsp_status_in = ST_OK;
         end else begin
            rsp_page_in   = '0;
            rsp_status_in = ST_NO_MEM;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            REG_REGION_START: region_start_in = csr_ch.data;
            REG_REGION_END:   region_end_in   = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // Control registers and list heads (head index is left as is on reset)
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         region_start_ff <= REGION_START_RESET;
         region_end_ff   <= REGION_END_RESET;
         for (int i = 0; i < NUM_CPUS; i++) begin
            heads_ff[i].valid <= 1'b0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         region_start_ff <= region_start_in;
         region_end_ff   <= region_end_in;
         for (int i = 0; i < NUM_CPUS; i++) begin
            heads_ff[i] <= heads_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pop_list_ff   <= pop_list_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

/* src/pcpa_link_ram.sv */
// Next-link memory: one link per page, one write and one registered read a cycle.
`timescale 1ns / 1ps
module pcpa_link_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [pcpa_pkg::PAGE_IDX_W-1:0]   wr_addr,
   input  pcpa_pkg::link_type                wr_data,
   input  logic                              rd_en,
   input  logic [pcpa_pkg::PAGE_IDX_W-1:0]   rd_addr,
   output pcpa_pkg::link_type                rd_data
);
   import pcpa_pkg::*;

   link_type link_mem [NUM_PAGES];
   link_type rd_data_ff;

   // Contents undefined until written; no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pcpa_free_check.sv */
// Free address check: alignment, region bounds and page range.
`timescale 1ns / 1ps
module pcpa_free_check (
   input  logic [pcpa_pkg::ADDR_W-1:0] address,
   input  logic [pcpa_pkg::ADDR_W-1:0] region_start,
   input  logic [pcpa_pkg::ADDR_W-1:0] region_end,
   output pcpa_pkg::check_type         result
);
   import pcpa_pkg::*;

   logic                  aligned;
   logic                  in_region;
   logic                  in_store;
   logic [PAGE_NUM_W-1:0] page_num;

   assign page_num  = address[ADDR_W-1:PAGE_SHIFT];
   assign aligned   = (address[PAGE_SHIFT-1:0] == '0);
   assign in_region = (address >= region_start) && (address < region_end);
   // page number must fall inside the link store
   assign in_store  = ((ADDR_W + 1)'(page_num) < (ADDR_W + 1)'(NUM_PAGES));

   assign result.ok  = aligned && in_region && in_store;
   assign result.idx = PAGE_IDX_W'(page_num);

endmodule
